// ===== rtl/core/sparse_image_unpack_fade_unit_macros.svh =====
// ----------------------------------------------------------------------------
// sparse image unpack fade unit assertion macros
// concurrent assertion shorthands, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SPARSE_IMAGE_UNPACK_FADE_UNIT_MACROS_SVH
`define SPARSE_IMAGE_UNPACK_FADE_UNIT_MACROS_SVH

// same-cycle implication
`define SIUF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SIUF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/siuf_pkg.sv =====
// ----------------------------------------------------------------------------
// siuf_pkg
// shared types, constants and the fade arithmetic of the unpack fade unit
// ----------------------------------------------------------------------------
package siuf_pkg;

	localparam int WORD_W        = 32;
	localparam int OUT_ADDR_W    = 20;
	localparam int CONTRAST_W    = 9;
	localparam int CNT_W         = 14;
	localparam int ADV_W         = 17;
	localparam int ADDR_BITS_DEF = 20;
	localparam int QUEUE_DEPTH   = 2;
	localparam int PADDR_W       = 3;
	localparam int END_BIT       = 31;
	localparam int CNT_LSB       = 17;

	// register index, taken from paddr[2]
	localparam logic REG_CONTRAST  = 1'b0;
	localparam logic REG_DEST_BASE = 1'b1;

	typedef logic [WORD_W-1:0]            word_t;
	typedef logic [OUT_ADDR_W-1:0]        out_addr_t;
	typedef logic signed [CONTRAST_W-1:0] contrast_t;
	typedef logic [CNT_W-1:0]             cnt_t;

	typedef struct packed {
		logic      done;
		out_addr_t addr;
		word_t     word;
	} op_t;

	typedef struct packed {
		logic      load_base;
		out_addr_t base;
	} cfg_t;

	function automatic logic [7:0] fade_byte(input logic [7:0] b, input contrast_t c);
		logic signed [CONTRAST_W:0] v;
		v = signed'({2'b00, b}) + signed'({c[CONTRAST_W-1], c});
		if (v < 0)
			return 8'h00;
		else if (v > 255)
			return 8'hff;
		else
			return v[7:0];
	endfunction

	function automatic word_t fade_pixel(input word_t w, input contrast_t c);
		word_t r;
		for (int i = 0; i < 4; i++)
			r[8*i +: 8] = fade_byte(w[8*i +: 8], c);
		return r;
	endfunction

endpackage

// ===== rtl/core/siuf_if.sv =====
// ----------------------------------------------------------------------------
// siuf stream interfaces
// valid/ready channels for input words and output results
// ----------------------------------------------------------------------------
interface siuf_stream_if;
	import siuf_pkg::*;
	logic  valid;
	logic  ready;
	word_t word;
	modport source(output valid, output word, input ready);
	modport sink(input valid, input word, output ready);
endinterface

interface siuf_result_if;
	import siuf_pkg::*;
	logic      valid;
	logic      ready;
	out_addr_t write_address;
	word_t     pixel;
	logic      image_done;
	modport source(output valid, output write_address, output pixel, output image_done,
		input ready);
	modport sink(input valid, input write_address, input pixel, input image_done,
		output ready);
endinterface

// ===== rtl/core/siuf_front.sv =====
// ----------------------------------------------------------------------------
// siuf_front
// parses header and pixel words, tracks phase, count and write address
// ----------------------------------------------------------------------------
module siuf_front #(
	parameter int ADDR_BITS = siuf_pkg::ADDR_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	siuf_stream_if.sink    stream,
	input  siuf_pkg::cfg_t cfg,
	input  logic           full,
	output logic           push,
	output siuf_pkg::op_t  op
);
	import siuf_pkg::*;

	logic                 in_pixels_q;
	cnt_t                 pixels_left_q;
	logic [ADDR_BITS-1:0] cur_addr_q;
	logic                 accept;
	cnt_t                 left_dec;
	logic [ADDR_BITS+OUT_ADDR_W-1:0] cur_ext;
	logic [ADDR_BITS+OUT_ADDR_W-1:0] base_ext;
	logic [ADDR_BITS+ADV_W-1:0]      adv_ext;
	logic [ADDR_BITS-1:0]            base_a;

	assign stream.ready = !full;
	assign accept   = stream.valid && stream.ready;
	assign left_dec = pixels_left_q - cnt_t'(1);
	assign cur_ext  = {{OUT_ADDR_W{1'b0}}, cur_addr_q};
	assign base_ext = {{ADDR_BITS{1'b0}}, cfg.base};
	assign adv_ext  = {{ADDR_BITS{1'b0}}, stream.word[ADV_W-1:0]};
	assign base_a   = base_ext[ADDR_BITS-1:0];

	assign push    = accept && (in_pixels_q || stream.word[END_BIT]);
	assign op.done = !in_pixels_q;
	assign op.addr = in_pixels_q ? cur_ext[OUT_ADDR_W-1:0] : '0;
	assign op.word = in_pixels_q ? stream.word : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pixels_q   <= 1'b0;
			pixels_left_q <= '0;
			cur_addr_q    <= '0;
		end else if (cfg.load_base) begin
			cur_addr_q <= base_a;
		end else if (accept) begin
			if (in_pixels_q) begin
				cur_addr_q    <= cur_addr_q + ADDR_BITS'(1);
				pixels_left_q <= left_dec;
				if (left_dec == '0)
					in_pixels_q <= 1'b0;
			end else if (stream.word[END_BIT]) begin
				cur_addr_q    <= base_a;
				pixels_left_q <= '0;
			end else begin
				cur_addr_q    <= cur_addr_q + adv_ext[ADDR_BITS-1:0];
				pixels_left_q <= stream.word[CNT_LSB +: CNT_W];
				in_pixels_q   <= (stream.word[CNT_LSB +: CNT_W] != '0);
			end
		end
	end

endmodule

// ===== rtl/core/siuf_queue.sv =====
// ----------------------------------------------------------------------------
// siuf_queue
// short fifo of parsed operations between front and back
// ----------------------------------------------------------------------------
module siuf_queue #(
	parameter int DEPTH = siuf_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  siuf_pkg::op_t din,
	output logic          full,
	input  logic          pop,
	output siuf_pkg::op_t dout,
	output logic          empty
);
	import siuf_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	op_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

// ===== rtl/core/siuf_back.sv =====
// ----------------------------------------------------------------------------
// siuf_back
// applies the fade to pixel operations and holds the result register
// ----------------------------------------------------------------------------
module siuf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  siuf_pkg::op_t       op,
	input  logic                empty,
	input  siuf_pkg::contrast_t contrast,
	output logic                pop,
	siuf_result_if.source       result
);
	import siuf_pkg::*;

	logic      valid_q;
	out_addr_t addr_q;
	word_t     pixel_q;
	logic      done_q;

	assign pop = !empty && (!valid_q || result.ready);

	assign result.valid         = valid_q;
	assign result.write_address = addr_q;
	assign result.pixel         = pixel_q;
	assign result.image_done    = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= pop || (valid_q && !result.ready);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			addr_q  <= op.addr;
			pixel_q <= op.done ? '0 : fade_pixel(op.word, contrast);
			done_q  <= op.done;
		end
	end

endmodule

// ===== rtl/core/sparse_image_unpack_fade_unit.sv =====
// ----------------------------------------------------------------------------
// sparse_image_unpack_fade_unit
// unpacks a sparse rgba word stream and fades every pixel
//
//  channel  dir  handshake       payload
//  stream   in   valid/ready     word
//  result   out  valid/ready     write_address, pixel, image_done
//  apb      in   psel/penable    contrast, destination_base
//
// one word per cycle sustained while result is not back-pressured; an accepted word
// reaches result through a two-entry queue and the output register
// header words other than end of image produce no transaction
// stream stalls only when the queue is full, i.e. result back-pressure
// reset clears phase, count, address, contrast and base
// ----------------------------------------------------------------------------
module sparse_image_unpack_fade_unit #(
	parameter int ADDR_BITS = siuf_pkg::ADDR_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	siuf_stream_if.sink                  stream,
	siuf_result_if.source                result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [siuf_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import siuf_pkg::*;

	contrast_t contrast_q;
	out_addr_t base_q;
	logic      wr_en;
	cfg_t      cfg;
	op_t       op_in;
	op_t       op_out;
	logic      push;
	logic      pop;
	logic      full;
	logic      empty;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			contrast_q <= '0;
			base_q     <= '0;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_CONTRAST:  contrast_q <= pwdata[CONTRAST_W-1:0];
				REG_DEST_BASE: base_q     <= pwdata[OUT_ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_CONTRAST:  prdata = 32'(contrast_q);
			REG_DEST_BASE: prdata = {{(32-OUT_ADDR_W){1'b0}}, base_q};
			default:       prdata = '0;
		endcase
	end

	// new base on a write, the stored base for end of image
	assign cfg.load_base = wr_en && (paddr[2] == REG_DEST_BASE);
	assign cfg.base      = cfg.load_base ? pwdata[OUT_ADDR_W-1:0] : base_q;

	siuf_front #(.ADDR_BITS(ADDR_BITS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.cfg    (cfg),
		.full   (full),
		.push   (push),
		.op     (op_in)
	);

	siuf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (op_in),
		.full   (full),
		.pop    (pop),
		.dout   (op_out),
		.empty  (empty)
	);

	siuf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op_out),
		.empty    (empty),
		.contrast (contrast_q),
		.pop      (pop),
		.result   (result)
	);

endmodule

// ===== rtl/core/siuf_checker.sv =====
// ----------------------------------------------------------------------------
// siuf_checker
// port-level checks on the unpack fade unit, bound to the top level
// ----------------------------------------------------------------------------
`include "sparse_image_unpack_fade_unit_macros.svh"

module siuf_port_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         r_valid,
	input logic                         r_ready,
	input siuf_pkg::out_addr_t          r_addr,
	input siuf_pkg::word_t              r_pixel,
	input logic                         r_done,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic                         pready,
	input logic [siuf_pkg::PADDR_W-1:0] paddr,
	input logic [31:0]                  pwdata,
	input logic [31:0]                  prdata
);
	import siuf_pkg::*;

	logic wr_contrast;
	logic rd_contrast;

	assign rd_contrast = (paddr[2] == REG_CONTRAST);
	assign wr_contrast = psel && penable && pwrite && pready && rd_contrast;

	`SIUF_ASSERT_NEXT(a_hold_valid, r_valid && !r_ready, r_valid, "result dropped while stalled")
	`SIUF_ASSERT_NEXT(a_hold_data, r_valid && !r_ready, $stable({r_addr, r_pixel, r_done}), "result changed")
	`SIUF_ASSERT_NOW(a_done_zero, r_valid && r_done, r_pixel == '0 && r_addr == '0, "end of image data")
	`SIUF_ASSERT_NEXT(a_contrast_rb, wr_contrast, !rd_contrast || prdata[8:0] == $past(pwdata[8:0]), "readback")

endmodule

bind sparse_image_unpack_fade_unit siuf_port_checker u_siuf_port_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.r_valid (result.valid),
	.r_ready (result.ready),
	.r_addr  (result.write_address),
	.r_pixel (result.pixel),
	.r_done  (result.image_done),
	.psel    (psel),
	.penable (penable),
	.pwrite  (pwrite),
	.pready  (pready),
	.paddr   (paddr),
	.pwdata  (pwdata),
	.prdata  (prdata)
);

// ===== verif/siuf_checker.sv =====
// ----------------------------------------------------------------------------
// siuf_checker
// follows the register writes and the accepted stream words and works out
// which pixel writes and end-of-image markers must come out, then checks every
// result transaction against the oldest one still owed
// ----------------------------------------------------------------------------
module siuf_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	siuf_stream_if                       stream,
	siuf_result_if                       result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [siuf_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output int                           errors,
	output int                           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import siuf_pkg::*;

	typedef struct {
		out_addr_t addr;
		word_t     pixel;
		logic      done;
	} pixel_write_t;

	pixel_write_t queued_writes[$];
	pixel_write_t owed;
	pixel_write_t seen;

	contrast_t fade;
	out_addr_t base_addr;
	out_addr_t next_addr;
	cnt_t      body_left;
	logic      in_body;
	word_t     w;

	function automatic word_t dim_rgba(input word_t px, input contrast_t c);
		int    v;
		word_t r;
		for (int i = 0; i < 4; i++) begin
			v = int'(px[8*i +: 8]) + int'(c);
			if (v < 0)
				v = 0;
			if (v > 255)
				v = 255;
			r[8*i +: 8] = v[7:0];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queued_writes.delete();
			fade      = '0;
			base_addr = '0;
			next_addr = '0;
			body_left = '0;
			in_body   = 1'b0;
			errors    = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_CONTRAST) begin
					fade = pwdata[CONTRAST_W-1:0];
				end else begin
					base_addr = pwdata[OUT_ADDR_W-1:0];
					next_addr = base_addr;
				end
			end

			if (result.valid && result.ready) begin
				seen.addr  = result.write_address;
				seen.pixel = result.pixel;
				seen.done  = result.image_done;
				if (queued_writes.size() == 0) begin
					$display("%0t: unexpected result, got addr %05h pixel %08h done %0b",
						$time, seen.addr, seen.pixel, seen.done);
					errors++;
				end else begin
					owed = queued_writes.pop_front();
					if (seen.addr !== owed.addr || seen.pixel !== owed.pixel
							|| seen.done !== owed.done) begin
						$display("%0t: mismatch, exp %05h %08h %0b, got %05h %08h %0b",
							$time, owed.addr, owed.pixel, owed.done,
							seen.addr, seen.pixel, seen.done);
						errors++;
					end
				end
			end

			if (stream.valid && stream.ready) begin
				w = stream.word;
				if (in_body) begin
					owed.addr  = next_addr;
					owed.pixel = dim_rgba(w, fade);
					owed.done  = 1'b0;
					queued_writes.push_back(owed);
					next_addr = next_addr + out_addr_t'(1);
					body_left = body_left - cnt_t'(1);
					if (body_left == 0)
						in_body = 1'b0;
				end else if (w[END_BIT]) begin
					owed.addr  = '0;
					owed.pixel = '0;
					owed.done  = 1'b1;
					queued_writes.push_back(owed);
					next_addr = base_addr;
					body_left = '0;
				end else begin
					next_addr = next_addr + out_addr_t'(w[ADV_W-1:0]);
					body_left = w[CNT_LSB +: CNT_W];
					in_body   = (body_left != 0);
				end
			end
		end
		pending = queued_writes.size();
	end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives sparse image streams through the unpack fade unit under random
// idling on both channels, changes contrast and base between phases over
// their extremes, and reports the verdict of the checker
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import siuf_pkg::*;

	localparam int STREAM_ITEMS   = 850;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	siuf_stream_if stream_ch();
	siuf_result_if result_ch();

	int errors;
	int pending;
	int words_sent;
	int quiet_cycles;
	int cur_contrast;
	bit calm;

	sparse_image_unpack_fade_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (stream_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	siuf_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (stream_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.pready  (pready),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.errors  (errors),
		.pending (pending)
	);

	always #5 clk = ~clk;

	function automatic int draw_gap();
		if (calm || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 13);
	endfunction

	function automatic word_t pick_pixel();
		word_t px;
		for (int i = 0; i < 4; i++) begin
			case ($urandom_range(0, 4))
				0:       px[8*i +: 8] = 8'h00;
				1:       px[8*i +: 8] = 8'hff;
				2:       px[8*i +: 8] = 8'(-cur_contrast + $urandom_range(0, 4) - 2);
				default: px[8*i +: 8] = 8'($urandom);
			endcase
		end
		return px;
	endfunction

	task automatic send_word(input word_t w);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			stream_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stream_ch.valid <= 1'b1;
		stream_ch.word  <= w;
		do @(posedge clk); while (!stream_ch.ready);
		words_sent++;
	endtask

	task automatic send_header(input int adv, input int count);
		send_word({1'b0, 14'(count), 17'(adv)});
	endtask

	task automatic send_pixels(input int n);
		for (int i = 0; i < n; i++)
			send_word(pick_pixel());
	endtask

	task automatic settle();
		stream_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_contrast(input int c);
		cur_contrast = c;
		write_reg(REG_CONTRAST, 32'(c));
	endtask

	task automatic send_image();
		int segs;
		int adv;
		int n_px;
		segs = $urandom_range(0, 4);
		for (int s = 0; s < segs; s++) begin
			adv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 17'h1ffff)
				: $urandom_range(0, 40);
			n_px = $urandom_range(0, 7);
			send_header(adv, n_px);
			send_pixels(n_px);
		end
		send_word({1'b1, 31'($urandom)});
	endtask

	initial begin
		arst_n          <= 1'b0;
		psel            <= 1'b0;
		penable         <= 1'b0;
		pwrite          <= 1'b0;
		paddr           <= '0;
		pwdata          <= '0;
		stream_ch.valid <= 1'b0;
		stream_ch.word  <= '0;
	end

	initial begin
		int gap;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((stream_ch.valid && stream_ch.ready) || (result_ch.valid && result_ch.ready)
					|| (psel && penable)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("testbench: done, errors");
					$finish;
				end
			end
		end
	end

	initial begin
		int pick;
		quiet_cycles = 0;
		words_sent   = 0;
		cur_contrast = 0;
		calm         = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, empty segments and back to back ends of image
		send_header(0, 2);
		send_word(32'h0000_0000);
		send_word(32'hffff_ffff);
		send_word(32'h0001_ffff);
		send_header(3, 1);
		send_word(32'h1234_5678);
		send_word(32'h8000_0000);
		send_word(32'hffff_ffff);
		send_word(32'h0000_0000);
		settle();

		// strongest fade with the address wrapping at the top of the space
		set_contrast(-255);
		write_reg(REG_DEST_BASE, 32'h000f_ffff);
		send_header(0, 3);
		send_word(32'hff00_fe01);
		send_word(32'h80ff_ff00);
		send_word(32'hffff_ffff);
		send_word(32'h8000_0001);
		send_header(17'h1ffff, 1);
		send_word(32'h0102_0304);
		send_word(32'hc000_0000);
		settle();

		// largest positive contrast saturates high
		set_contrast(255);
		write_reg(REG_DEST_BASE, 32'h0000_0000);
		send_header(0, 2);
		send_word(32'h01ff_8000);
		send_word(32'h0000_0000);
		send_word(32'h8000_0000);
		settle();

		// most negative contrast, then a base rewrite inside a segment
		set_contrast(-256);
		send_header(1, 2);
		send_word(32'hffff_ffff);
		settle();
		write_reg(REG_DEST_BASE, 32'h0000_0abc);
		send_word(32'h7f80_0100);
		send_word(32'h8000_0000);
		settle();

		// random images, new settings now and then with the unit drained
		while (words_sent < STREAM_ITEMS) begin
			if ($urandom_range(0, 5) == 0) begin
				settle();
				calm = ($urandom_range(0, 7) == 0);
				pick = $urandom_range(0, 3);
				case (pick)
					0:       set_contrast(0);
					1:       set_contrast(-255);
					default: set_contrast(-int'($urandom_range(0, 255)));
				endcase
				write_reg(REG_DEST_BASE, 32'($urandom_range(0, 20'hfffff)));
			end
			send_image();
		end
		settle();

		if (errors == 0 && pending == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
